// ----- hw/rtl/zeo_pkg.sv -----
// Shared types, register indexes, mode codes and reset values for the zebra overlay.
`default_nettype none

package zeo_pkg;

    localparam int COORD_BITS_DEF  = 10;
    localparam int LINE_WIDTH_BITS = 10;
    localparam int CFG_DATA_BITS   = 10;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int MODE_BITS       = 3;
    localparam int FRAME_BITS      = 4;
    localparam int LUMA_BITS       = 8;
    localparam int COLOR_BITS      = 8;

    localparam logic OP_FRAME_START = 1'b0;
    localparam logic OP_PIXEL       = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MARK_MODE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OVER_MARGIN = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNDER_LEVEL = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OVER_COLOR  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNDER_COLOR = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLEAR_COLOR = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH  = 3'd6;

    localparam logic [MODE_BITS-1:0] MODE_STRIPE4 = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_STRIPE8 = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SOLID   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_BLINK1  = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_BLINK2  = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_BLINK3  = 3'd5;

    localparam logic [FRAME_BITS-1:0] MASK_STRIPE4 = 4'd4;
    localparam logic [FRAME_BITS-1:0] MASK_STRIPE8 = 4'd8;
    localparam logic [FRAME_BITS-1:0] MASK_SOLID   = 4'd1;

    localparam logic [LUMA_BITS-1:0] LUMA_MAX = 8'hFF;

    localparam logic [MODE_BITS-1:0]       MARK_MODE_RST  = MODE_SOLID;
    localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RST = 10'd360;

    typedef logic [COLOR_BITS-1:0] color_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] mark_mode;
        logic [LUMA_BITS-1:0] over_margin;
        logic [LUMA_BITS-1:0] under_level;
        color_t               over_color;
        color_t               under_color;
        color_t               clear_color;
    } zeo_cfg_t;

    typedef struct packed {
        logic                  pixel;
        logic [LUMA_BITS-1:0]  luma;
        logic [FRAME_BITS-1:0] frame_count;
    } zeo_ctx_t;

endpackage

`default_nettype wire

// ----- hw/rtl/zeo_tracker.sv -----
// Input stage: frame, column and row counters and the registered pixel context.
`default_nettype none

module zeo_tracker
    import zeo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       operation,
    input  wire logic [LUMA_BITS-1:0]       luma,
    input  wire logic [LINE_WIDTH_BITS-1:0] line_width,
    input  wire logic                       s2_ready,
    output logic                            s1_valid,
    output zeo_ctx_t                        s1_ctx,
    output logic [COORD_BITS-1:0]           s1_row,
    output logic [COORD_BITS-1:0]           s1_column
);

    localparam int CMP_BITS = (COORD_BITS + 1 > LINE_WIDTH_BITS) ?
                              COORD_BITS + 1 : LINE_WIDTH_BITS;

    logic                  s1_valid_reg;
    zeo_ctx_t              s1_ctx_reg;
    logic [COORD_BITS-1:0] s1_row_reg;
    logic [COORD_BITS-1:0] s1_column_reg;

    logic [FRAME_BITS-1:0] frame_count_reg, frame_count_next;
    logic [COORD_BITS-1:0] column_reg, column_next;
    logic [COORD_BITS-1:0] row_reg, row_next;

    logic                  in_xfer;
    logic [CMP_BITS-1:0]   column_inc;
    logic [CMP_BITS-1:0]   width_ext;
    logic                  row_end;

    assign in_ready = !s1_valid_reg || s2_ready;
    assign in_xfer  = in_valid && in_ready;

    assign column_inc = CMP_BITS'(column_reg) + CMP_BITS'(1);
    assign width_ext  = CMP_BITS'(line_width);
    assign row_end    = (column_inc >= width_ext) || (column_reg == {COORD_BITS{1'b1}});

    always_comb
    begin
        frame_count_next = frame_count_reg;
        column_next      = column_reg;
        row_next         = row_reg;
        if (operation == OP_FRAME_START)
        begin
            frame_count_next = frame_count_reg + FRAME_BITS'(1);
            column_next      = '0;
            row_next         = '0;
        end
        else if (row_end)
        begin
            column_next = '0;
            row_next    = row_reg + COORD_BITS'(1);
        end
        else
        begin
            column_next = column_inc[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            column_reg      <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                frame_count_reg <= frame_count_next;
                column_reg      <= column_next;
                row_reg         <= row_next;
                s1_valid_reg    <= 1'b1;
            end
            else if (s2_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // context holds the counter values the pixel is judged against
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_ctx_reg.pixel       <= (operation == OP_PIXEL);
            s1_ctx_reg.luma        <= luma;
            s1_ctx_reg.frame_count <= frame_count_next;
            s1_row_reg             <= row_reg;
            s1_column_reg          <= column_reg;
        end
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_ctx    = s1_ctx_reg;
    assign s1_row    = s1_row_reg;
    assign s1_column = s1_column_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/zeo_classify.sv -----
// Result stage: exposure classification, stripe and blink masking, output register.
`default_nettype none

module zeo_classify
    import zeo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s1_valid,
    input  wire zeo_ctx_t              s1_ctx,
    input  wire logic [COORD_BITS-1:0] s1_row,
    input  wire logic [COORD_BITS-1:0] s1_column,
    input  wire zeo_cfg_t              cfg,
    output logic                       s2_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output color_t                     pixel_color,
    output logic                       frame_shown
);

    logic                  out_valid_reg;
    color_t                pixel_color_reg, pixel_color_next;
    logic                  frame_shown_reg, frame_shown_next;

    logic [FRAME_BITS-1:0] mask;
    logic                  striped;
    logic                  stripe_on;
    logic [COORD_BITS-1:0] phase;
    logic [LUMA_BITS-1:0]  over_level;

    always_comb
    begin
        unique case (cfg.mark_mode)
            MODE_STRIPE4: mask = MASK_STRIPE4;
            MODE_STRIPE8: mask = MASK_STRIPE8;
            MODE_SOLID:   mask = MASK_SOLID;
            MODE_BLINK1:  mask = s1_ctx.frame_count & 4'b0010;
            MODE_BLINK3:  mask = s1_ctx.frame_count & 4'b1000;
            default:      mask = s1_ctx.frame_count & 4'b0100;
        endcase
    end

    assign striped    = (cfg.mark_mode == MODE_STRIPE4) || (cfg.mark_mode == MODE_STRIPE8);
    assign phase      = s1_row - s1_column - COORD_BITS'(s1_ctx.frame_count);
    assign stripe_on  = !striped || ((phase[FRAME_BITS-1:0] & mask) != '0);
    assign over_level = LUMA_MAX - cfg.over_margin;

    always_comb
    begin
        frame_shown_next = (mask != '0);
        pixel_color_next = cfg.clear_color;
        if (s1_ctx.pixel && frame_shown_next && stripe_on)
        begin
            if (s1_ctx.luma > over_level)
                pixel_color_next = cfg.over_color;
            else if (s1_ctx.luma < cfg.under_level)
                pixel_color_next = cfg.under_color;
        end
    end

    assign s2_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid)
        begin
            pixel_color_reg <= pixel_color_next;
            frame_shown_reg <= frame_shown_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = pixel_color_reg;
    assign frame_shown = frame_shown_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/zebra_exposure_overlay_unit.sv -----
// Top level of the zebra exposure overlay: configuration registers and the two stages.
`default_nettype none

// Classifies one luma byte per pixel (or a frame-start marker) into an overlay
// palette index, one result per input transfer. Throughput is one transfer per
// clock while the result register is not stalled; an input register holds the pixel
// with its frame, row and column counts, then the classification logic feeds the result
// register. Both stages stall only when the result register is full and not
// taken. Configuration writes are always ready and take effect on the next
// cycle; write them while no transfer is in flight.
module zebra_exposure_overlay_unit
    import zeo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      operation,
    input  wire logic [LUMA_BITS-1:0]      luma,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [COLOR_BITS-1:0]          pixel_color,
    output logic                           frame_shown
);

    zeo_cfg_t                   cfg_reg;
    logic [LINE_WIDTH_BITS-1:0] line_width_reg;

    logic                       s2_ready;
    logic                       s1_valid;
    zeo_ctx_t                   s1_ctx;
    logic [COORD_BITS-1:0]      s1_row;
    logic [COORD_BITS-1:0]      s1_column;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mark_mode   <= MARK_MODE_RST;
            cfg_reg.over_margin <= '0;
            cfg_reg.under_level <= '0;
            cfg_reg.over_color  <= '0;
            cfg_reg.under_color <= '0;
            cfg_reg.clear_color <= '0;
            line_width_reg      <= LINE_WIDTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MARK_MODE:   cfg_reg.mark_mode   <= cfg_data[MODE_BITS-1:0];
                REG_OVER_MARGIN: cfg_reg.over_margin <= cfg_data[LUMA_BITS-1:0];
                REG_UNDER_LEVEL: cfg_reg.under_level <= cfg_data[LUMA_BITS-1:0];
                REG_OVER_COLOR:  cfg_reg.over_color  <= cfg_data[COLOR_BITS-1:0];
                REG_UNDER_COLOR: cfg_reg.under_color <= cfg_data[COLOR_BITS-1:0];
                REG_CLEAR_COLOR: cfg_reg.clear_color <= cfg_data[COLOR_BITS-1:0];
                REG_LINE_WIDTH:  line_width_reg      <= cfg_data[LINE_WIDTH_BITS-1:0];
                default:         ;
            endcase
        end
    end

    zeo_tracker #(
        .COORD_BITS (COORD_BITS)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .luma       (luma),
        .line_width (line_width_reg),
        .s2_ready   (s2_ready),
        .s1_valid   (s1_valid),
        .s1_ctx     (s1_ctx),
        .s1_row     (s1_row),
        .s1_column  (s1_column)
    );

    zeo_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid),
        .s1_ctx      (s1_ctx),
        .s1_row      (s1_row),
        .s1_column   (s1_column),
        .cfg         (cfg_reg),
        .s2_ready    (s2_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_color (pixel_color),
        .frame_shown (frame_shown)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/zeo_checker.sv -----
// Port-level checks for the zebra overlay, bound to the top level.
`default_nettype none

module zeo_checker
    import zeo_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      cfg_valid,
    input wire logic                      cfg_ready,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [COLOR_BITS-1:0]     pixel_color,
    input wire logic                      frame_shown
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_color) && $stable(frame_shown))
        else $error("result changed while stalled");

    // input side only backs up when both stages are full and the output is stalled
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // an input transfer reaches the output register when the output drains
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("transfer did not reach the output");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind zebra_exposure_overlay_unit zeo_checker u_zeo_checker (.*);

`default_nettype wire
